// ===== sv/gda_pkg.sv =====
// Shared types, constants and calendar helpers for the Gregorian date add/difference block.
// No dependencies; imported by gregorian_date_add_and_difference and its testbench.
package gda_pkg;

    localparam int YEAR_W = 14;
    localparam int MONTH_W = 4;
    localparam int DOM_W = 5;
    localparam int STATUS_W = 2;

    // bits needed for a day serial of 0001-01-01 .. 9999-12-31
    localparam int SER_W = 22;
    localparam int OFFSET_BITS_DEF = 23;

    localparam int DAYS_400Y = 146097;
    localparam int DAYS_100Y = 36524;
    localparam int DAYS_4Y = 1461;
    localparam int DAYS_1Y = 365;
    localparam int MAX_SERIAL = 3652058;

    localparam int YEARS_400 = 400;
    localparam int YEARS_100 = 100;
    localparam int YEARS_4 = 4;
    localparam int YEARS_1 = 1;

    localparam logic [YEAR_W-1:0] YEAR_MIN = 14'd1;
    localparam logic [YEAR_W-1:0] YEAR_MAX = 14'd9999;
    localparam logic [MONTH_W-1:0] MONTH_FIRST = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_LAST = 4'd12;

    localparam logic CMD_ADD = 1'b0;
    localparam logic CMD_DIFF = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_DATE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_T400,
        S_T100,
        S_T4,
        S_T1,
        S_TCHK,
        S_TMON,
        S_TEND,
        S_FRNG,
        S_F400,
        S_F100,
        S_F4,
        S_F1,
        S_FMON
    } state_t;

    // Days in a month; codes outside 1..12 give zero.
    function automatic logic [DOM_W-1:0] month_len(input logic [MONTH_W-1:0] mo,
                                                    input logic leap);
        logic [DOM_W-1:0] len;
        begin
            case (mo)
                4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
                4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
                4'd2: len = leap ? 5'd29 : 5'd28;
                default: len = 5'd0;
            endcase
            return len;
        end
    endfunction

    // Leap test from the period split of (year - 1): 100s, 4s and single years
    // left after removing whole 400-year cycles.
    function automatic logic is_leap(input logic [1:0] q100,
                                     input logic [4:0] q4,
                                     input logic [1:0] q1);
        begin
            return (q1 == 2'd3) && ((q4 != 5'd24) || (q100 == 2'd3));
        end
    endfunction

endpackage

// ===== sv/gregorian_date_add_and_difference.sv =====
// Top level of the Gregorian date add/difference block: sequencer and datapath registers.
// Depends on gda_pkg and gda_alu.
//
//  channel   ports                                                  handshake
//  --------  -----------------------------------------------------  ----------------------
//  request   command, year_a, month_a, dom_a, day_offset,           start high, busy low
//            year_b, month_b, dom_b
//  result    result_year, result_month, result_dom,                 done high, one cycle
//            day_difference, status
//
// A date with a field out of range is rejected at once, without raising busy.
// Each request runs on the shared step unit, whose steps remove one whole period
// (400, 100, 4 or 1 years) or one month, first to build a day serial from a date and,
// for an add, again to split the new serial back into a date; a difference builds two.
// Reset clears the sequencer and the done strobe; busy stays high from acceptance until
// the cycle that done is raised. The receiver takes done as is and cannot stall.
module gregorian_date_add_and_difference
    import gda_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      command,
    input  logic [YEAR_W-1:0]         year_a,
    input  logic [MONTH_W-1:0]        month_a,
    input  logic [DOM_W-1:0]          dom_a,
    input  logic signed [OFFSET_BITS-1:0] day_offset,
    input  logic [YEAR_W-1:0]         year_b,
    input  logic [MONTH_W-1:0]        month_b,
    input  logic [DOM_W-1:0]          dom_b,
    output logic                      done,
    output logic [YEAR_W-1:0]         result_year,
    output logic [MONTH_W-1:0]        result_month,
    output logic [DOM_W-1:0]          result_dom,
    output logic signed [OFFSET_BITS-1:0] day_difference,
    output logic [STATUS_W-1:0]       status
);

    // working width: holds serial + offset with sign
    localparam int SUM_W = ((OFFSET_BITS > SER_W + 1) ? OFFSET_BITS : SER_W + 1) + 1;
    localparam logic [SUM_W-1:0] SMAX =
        {{(SUM_W - OFFSET_BITS + 1){1'b0}}, {(OFFSET_BITS - 1){1'b1}}};
    localparam logic [SUM_W-1:0] SMIN = ~SMAX;

    function automatic logic date_in_range(input logic [YEAR_W-1:0] y,
                                           input logic [MONTH_W-1:0] m,
                                           input logic [DOM_W-1:0] d);
        begin
            return (y >= YEAR_MIN) && (y <= YEAR_MAX) && (m >= MONTH_FIRST)
                && (m <= MONTH_LAST) && (d != 5'd0);
        end
    endfunction

    state_t state_reg, state_next;

    logic                   cmd_reg, cmd_next;
    logic                   sel_b_reg, sel_b_next;
    logic [MONTH_W-1:0]     month_a_reg, month_a_next;
    logic [DOM_W-1:0]       dom_a_reg, dom_a_next;
    logic [YEAR_W-1:0]      year_b_reg, year_b_next;
    logic [MONTH_W-1:0]     month_b_reg, month_b_next;
    logic [DOM_W-1:0]       dom_b_reg, dom_b_next;
    logic [OFFSET_BITS-1:0] off_reg, off_next;

    logic [SUM_W-1:0]       rem_reg, rem_next;
    logic [SUM_W-1:0]       acc_reg, acc_next;
    logic [SUM_W-1:0]       ser_a_reg, ser_a_next;
    logic [1:0]             q100_reg, q100_next;
    logic [4:0]             q4_reg, q4_next;
    logic [1:0]             q1_reg, q1_next;
    logic [MONTH_W-1:0]     mo_reg, mo_next;

    logic                   done_reg, done_next;
    logic [YEAR_W-1:0]      ryear_reg, ryear_next;
    logic [MONTH_W-1:0]     rmonth_reg, rmonth_next;
    logic [DOM_W-1:0]       rdom_reg, rdom_next;
    logic [OFFSET_BITS-1:0] rdiff_reg, rdiff_next;
    logic [STATUS_W-1:0]    rstat_reg, rstat_next;

    logic [SUM_W-1:0]       alu_opa, alu_opb, alu_acc, alu_addend;
    logic                   alu_ge;
    logic [SUM_W-1:0]       alu_dif, alu_sum;

    logic [MONTH_W-1:0]     cur_m;
    logic [DOM_W-1:0]       cur_d;
    logic                   leap;
    logic [DOM_W-1:0]       mlen;

    gda_alu #(
        .W(SUM_W)
    ) u_alu (
        .opa    (alu_opa),
        .opb    (alu_opb),
        .acc_in (alu_acc),
        .addend (alu_addend),
        .ge     (alu_ge),
        .dif    (alu_dif),
        .sum    (alu_sum)
    );

    assign cur_m = sel_b_reg ? month_b_reg : month_a_reg;
    assign cur_d = sel_b_reg ? dom_b_reg : dom_a_reg;
    assign leap = is_leap(q100_reg, q4_reg, q1_reg);
    assign mlen = month_len(mo_reg, leap);

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign result_year = ryear_reg;
    assign result_month = rmonth_reg;
    assign result_dom = rdom_reg;
    assign day_difference = rdiff_reg;
    assign status = rstat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        sel_b_reg <= sel_b_next;
        month_a_reg <= month_a_next;
        dom_a_reg <= dom_a_next;
        year_b_reg <= year_b_next;
        month_b_reg <= month_b_next;
        dom_b_reg <= dom_b_next;
        off_reg <= off_next;
        rem_reg <= rem_next;
        acc_reg <= acc_next;
        ser_a_reg <= ser_a_next;
        q100_reg <= q100_next;
        q4_reg <= q4_next;
        q1_reg <= q1_next;
        mo_reg <= mo_next;
        ryear_reg <= ryear_next;
        rmonth_reg <= rmonth_next;
        rdom_reg <= rdom_next;
        rdiff_reg <= rdiff_next;
        rstat_reg <= rstat_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd_next = cmd_reg;
        sel_b_next = sel_b_reg;
        month_a_next = month_a_reg;
        dom_a_next = dom_a_reg;
        year_b_next = year_b_reg;
        month_b_next = month_b_reg;
        dom_b_next = dom_b_reg;
        off_next = off_reg;
        rem_next = rem_reg;
        acc_next = acc_reg;
        ser_a_next = ser_a_reg;
        q100_next = q100_reg;
        q4_next = q4_reg;
        q1_next = q1_reg;
        mo_next = mo_reg;
        done_next = 1'b0;
        ryear_next = ryear_reg;
        rmonth_next = rmonth_reg;
        rdom_next = rdom_reg;
        rdiff_next = rdiff_reg;
        rstat_next = rstat_reg;

        alu_opa = rem_reg;
        alu_opb = '0;
        alu_acc = acc_reg;
        alu_addend = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next = command;
                    month_a_next = month_a;
                    dom_a_next = dom_a;
                    year_b_next = year_b;
                    month_b_next = month_b;
                    dom_b_next = dom_b;
                    off_next = day_offset;
                    // convert date A first: split (year - 1) into periods
                    rem_next = {{(SUM_W - YEAR_W){1'b0}}, year_a - YEAR_MIN};
                    acc_next = '0;
                    q100_next = '0;
                    q4_next = '0;
                    q1_next = '0;
                    mo_next = MONTH_FIRST;
                    sel_b_next = 1'b0;
                    if (!date_in_range(year_a, month_a, dom_a)
                        || (command == CMD_DIFF && !date_in_range(year_b, month_b, dom_b)))
                    begin
                        // reject at once, all other fields zero
                        done_next = 1'b1;
                        ryear_next = '0;
                        rmonth_next = '0;
                        rdom_next = '0;
                        rdiff_next = '0;
                        rstat_next = ST_BAD_DATE;
                    end
                    else
                    begin
                        state_next = S_T400;
                    end
                end
            end

            // date to serial: remove whole year periods, add their days
            S_T400:
            begin
                alu_opb = SUM_W'(YEARS_400);
                alu_addend = SUM_W'(DAYS_400Y);
                if (alu_ge)
                begin
                    rem_next = alu_dif;
                    acc_next = alu_sum;
                end
                else
                begin
                    state_next = S_T100;
                end
            end

            S_T100:
            begin
                alu_opb = SUM_W'(YEARS_100);
                alu_addend = SUM_W'(DAYS_100Y);
                if (alu_ge)
                begin
                    rem_next = alu_dif;
                    acc_next = alu_sum;
                    q100_next = q100_reg + 2'd1;
                end
                else
                begin
                    state_next = S_T4;
                end
            end

            S_T4:
            begin
                alu_opb = SUM_W'(YEARS_4);
                alu_addend = SUM_W'(DAYS_4Y);
                if (alu_ge)
                begin
                    rem_next = alu_dif;
                    acc_next = alu_sum;
                    q4_next = q4_reg + 5'd1;
                end
                else
                begin
                    state_next = S_T1;
                end
            end

            S_T1:
            begin
                alu_opb = SUM_W'(YEARS_1);
                alu_addend = SUM_W'(DAYS_1Y);
                if (alu_ge)
                begin
                    rem_next = alu_dif;
                    acc_next = alu_sum;
                    q1_next = q1_reg + 2'd1;
                end
                else
                begin
                    state_next = S_TCHK;
                end
            end

            // leap year is now known: check the day against the month length
            S_TCHK:
            begin
                if (cur_d > month_len(cur_m, leap))
                begin
                    state_next = S_IDLE;
                    done_next = 1'b1;
                    ryear_next = '0;
                    rmonth_next = '0;
                    rdom_next = '0;
                    rdiff_next = '0;
                    rstat_next = ST_BAD_DATE;
                end
                else
                begin
                    state_next = S_TMON;
                end
            end

            // add the lengths of the months before, then the day of month
            S_TMON:
            begin
                if (mo_reg < cur_m)
                begin
                    alu_addend = {{(SUM_W - DOM_W){1'b0}}, mlen};
                    acc_next = alu_sum;
                    mo_next = mo_reg + 4'd1;
                end
                else
                begin
                    alu_addend = {{(SUM_W - DOM_W){1'b0}}, cur_d - 5'd1};
                    acc_next = alu_sum;
                    state_next = S_TEND;
                end
            end

            S_TEND:
            begin
                if (cmd_reg == CMD_ADD)
                begin
                    alu_addend = {{(SUM_W - OFFSET_BITS){off_reg[OFFSET_BITS-1]}}, off_reg};
                    rem_next = alu_sum;
                    state_next = S_FRNG;
                end
                else if (!sel_b_reg)
                begin
                    // hold serial of A, start on date B
                    ser_a_next = acc_reg;
                    rem_next = {{(SUM_W - YEAR_W){1'b0}}, year_b_reg - YEAR_MIN};
                    acc_next = '0;
                    q100_next = '0;
                    q4_next = '0;
                    q1_next = '0;
                    mo_next = MONTH_FIRST;
                    sel_b_next = 1'b1;
                    state_next = S_T400;
                end
                else
                begin
                    alu_opa = ser_a_reg;
                    alu_opb = acc_reg;
                    state_next = S_IDLE;
                    done_next = 1'b1;
                    ryear_next = '0;
                    rmonth_next = '0;
                    rdom_next = '0;
                    rstat_next = ST_OK;
                    if ($signed(alu_dif) > $signed(SMAX))
                        rdiff_next = SMAX[OFFSET_BITS-1:0];
                    else if ($signed(alu_dif) < $signed(SMIN))
                        rdiff_next = SMIN[OFFSET_BITS-1:0];
                    else
                        rdiff_next = alu_dif[OFFSET_BITS-1:0];
                end
            end

            // sum serial must lie in the calendar range
            S_FRNG:
            begin
                acc_next = '0;
                q100_next = '0;
                q4_next = '0;
                q1_next = '0;
                mo_next = MONTH_FIRST;
                if (rem_reg[SUM_W-1] || ($signed(rem_reg) > $signed(SUM_W'(MAX_SERIAL))))
                begin
                    state_next = S_IDLE;
                    done_next = 1'b1;
                    ryear_next = '0;
                    rmonth_next = '0;
                    rdom_next = '0;
                    rdiff_next = '0;
                    rstat_next = ST_RANGE;
                end
                else
                begin
                    state_next = S_F400;
                end
            end

            // serial to date: remove whole periods of days, count years
            S_F400:
            begin
                alu_opb = SUM_W'(DAYS_400Y);
                alu_addend = SUM_W'(YEARS_400);
                if (alu_ge)
                begin
                    rem_next = alu_dif;
                    acc_next = alu_sum;
                end
                else
                begin
                    state_next = S_F100;
                end
            end

            S_F100:
            begin
                alu_opb = SUM_W'(DAYS_100Y);
                alu_addend = SUM_W'(YEARS_100);
                // the last day of a 400-year cycle stays in the fourth century
                if (alu_ge && q100_reg != 2'd3)
                begin
                    rem_next = alu_dif;
                    acc_next = alu_sum;
                    q100_next = q100_reg + 2'd1;
                end
                else
                begin
                    state_next = S_F4;
                end
            end

            S_F4:
            begin
                alu_opb = SUM_W'(DAYS_4Y);
                alu_addend = SUM_W'(YEARS_4);
                if (alu_ge)
                begin
                    rem_next = alu_dif;
                    acc_next = alu_sum;
                    q4_next = q4_reg + 5'd1;
                end
                else
                begin
                    state_next = S_F1;
                end
            end

            S_F1:
            begin
                alu_opb = SUM_W'(DAYS_1Y);
                alu_addend = SUM_W'(YEARS_1);
                // leap day of a 4-year group stays in its fourth year
                if (alu_ge && q1_reg != 2'd3)
                begin
                    rem_next = alu_dif;
                    acc_next = alu_sum;
                    q1_next = q1_reg + 2'd1;
                end
                else
                begin
                    state_next = S_FMON;
                end
            end

            // drop whole months; year = counted years + 1
            S_FMON:
            begin
                alu_opb = {{(SUM_W - DOM_W){1'b0}}, mlen};
                alu_addend = SUM_W'(YEARS_1);
                if (mo_reg < MONTH_LAST && alu_ge)
                begin
                    rem_next = alu_dif;
                    mo_next = mo_reg + 4'd1;
                end
                else
                begin
                    state_next = S_IDLE;
                    done_next = 1'b1;
                    ryear_next = alu_sum[YEAR_W-1:0];
                    rmonth_next = mo_reg;
                    rdom_next = rem_reg[DOM_W-1:0] + 5'd1;
                    rdiff_next = '0;
                    rstat_next = ST_OK;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/gda_alu.sv =====
// Shared arithmetic unit of the date sequencer: one compare/subtract and one add.
// Depends on nothing but its width parameter.
module gda_alu #(
    parameter int W = 24
) (
    input  logic [W-1:0] opa,
    input  logic [W-1:0] opb,
    input  logic [W-1:0] acc_in,
    input  logic [W-1:0] addend,
    output logic         ge,
    output logic [W-1:0] dif,
    output logic [W-1:0] sum
);

    assign ge = (opa >= opb);
    assign dif = opa - opb;
    assign sum = acc_in + addend;

endmodule

// ===== tb/tb_gregorian_date_add_and_difference.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for gregorian_date_add_and_difference: directed and random
// add/difference requests, each checked against a behavioral calendar predictor.
// Depends on gda_pkg and the gregorian_date_add_and_difference RTL.
module tb_gregorian_date_add_and_difference;
    import gda_pkg::*;

    localparam int OFF_W = OFFSET_BITS_DEF;
    localparam int RANDOM_REQUESTS = 700;
    // must outlast the slowest request plus the longest sender gap
    localparam int IDLE_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 300;
    localparam int RESET_CYCLES = 11;

    typedef struct {
        logic                    cmd;
        logic [YEAR_W-1:0]       year_a;
        logic [MONTH_W-1:0]      month_a;
        logic [DOM_W-1:0]        dom_a;
        logic signed [OFF_W-1:0] offset;
        logic [YEAR_W-1:0]       year_b;
        logic [MONTH_W-1:0]      month_b;
        logic [DOM_W-1:0]        dom_b;
    } date_req_t;

    typedef struct {
        logic [YEAR_W-1:0]       year;
        logic [MONTH_W-1:0]      month;
        logic [DOM_W-1:0]        dom;
        logic signed [OFF_W-1:0] diff;
        logic [STATUS_W-1:0]     status;
    } date_res_t;

    // DUT ports; every input starts at a known value
    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    busy;
    logic                    command = CMD_ADD;
    logic [YEAR_W-1:0]       year_a = '0;
    logic [MONTH_W-1:0]      month_a = '0;
    logic [DOM_W-1:0]        dom_a = '0;
    logic signed [OFF_W-1:0] day_offset = '0;
    logic [YEAR_W-1:0]       year_b = '0;
    logic [MONTH_W-1:0]      month_b = '0;
    logic [DOM_W-1:0]        dom_b = '0;
    logic                    done;
    logic [YEAR_W-1:0]       result_year;
    logic [MONTH_W-1:0]      result_month;
    logic [DOM_W-1:0]        result_dom;
    logic signed [OFF_W-1:0] day_difference;
    logic [STATUS_W-1:0]     status;

    date_req_t pending_requests[$];   // built up front, drained by the driver
    date_res_t awaited_results[$];    // one entry per accepted request, oldest first
    date_req_t active_request;        // request currently on the input ports

    int requests_sent = 0;
    int mismatches = 0;
    int idle_cycles = 0;
    int burst_left = 1;
    int gap_left = 0;

    gregorian_date_add_and_difference #(
        .OFFSET_BITS(OFF_W)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .command       (command),
        .year_a        (year_a),
        .month_a       (month_a),
        .dom_a         (dom_a),
        .day_offset    (day_offset),
        .year_b        (year_b),
        .month_b       (month_b),
        .dom_b         (dom_b),
        .done          (done),
        .result_year   (result_year),
        .result_month  (result_month),
        .result_dom    (result_dom),
        .day_difference(day_difference),
        .status        (status)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Calendar predictor
    // ------------------------------------------------------------------

    function automatic bit leap_year(int y);
        return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
    endfunction

    function automatic int month_days(int y, int m);
        case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11: return 30;
            2: return leap_year(y) ? 29 : 28;
            default: return 0;
        endcase
    endfunction

    function automatic bit date_ok(int y, int m, int d);
        if (y < 1 || y > 9999 || m < 1 || m > 12 || d < 1)
            return 1'b0;
        return d <= month_days(y, m);
    endfunction

    // Day count since 0001-01-01; only called on valid dates.
    function automatic int day_serial(int y, int m, int d);
        int past;
        int n;
        past = y - 1;
        n = past * 365 + past / 4 - past / 100 + past / 400;
        for (int k = 1; k < m; k++)
            n += month_days(y, k);
        return n + d - 1;
    endfunction

    // Inverse of day_serial for 0..MAX_SERIAL: peel whole periods, then months.
    function automatic void serial_to_date(int n, output int y, output int m, output int d);
        int c400, c100, c4, c1, rest;
        c400 = n / DAYS_400Y;
        rest = n % DAYS_400Y;
        c100 = rest / DAYS_100Y;
        // last day of a 400-year cycle still belongs to the fourth century
        if (c100 == 4)
            c100 = 3;
        rest -= c100 * DAYS_100Y;
        c4 = rest / DAYS_4Y;
        rest -= c4 * DAYS_4Y;
        c1 = rest / DAYS_1Y;
        // same for Dec 31 of a leap year at the end of a 4-year block
        if (c1 == 4)
            c1 = 3;
        rest -= c1 * DAYS_1Y;
        y = c400 * 400 + c100 * 100 + c4 * 4 + c1 + 1;
        m = 1;
        while (m < 12 && rest >= month_days(y, m))
        begin
            rest -= month_days(y, m);
            m++;
        end
        d = rest + 1;
    endfunction

    function automatic date_res_t calc_date_result(date_req_t r);
        date_res_t res;
        int sum, y, m, d;
        longint span, smax;
        res.year = '0;
        res.month = '0;
        res.dom = '0;
        res.diff = '0;
        res.status = ST_OK;
        if (!date_ok(r.year_a, r.month_a, r.dom_a) ||
            (r.cmd == CMD_DIFF && !date_ok(r.year_b, r.month_b, r.dom_b)))
        begin
            res.status = ST_BAD_DATE;
        end
        else if (r.cmd == CMD_ADD)
        begin
            sum = day_serial(r.year_a, r.month_a, r.dom_a) + int'(r.offset);
            if (sum < 0 || sum > MAX_SERIAL)
            begin
                res.status = ST_RANGE;
            end
            else
            begin
                serial_to_date(sum, y, m, d);
                res.year = YEAR_W'(y);
                res.month = MONTH_W'(m);
                res.dom = DOM_W'(d);
            end
        end
        else
        begin
            span = longint'(day_serial(r.year_a, r.month_a, r.dom_a)) -
                   longint'(day_serial(r.year_b, r.month_b, r.dom_b));
            // saturate to the offset width
            smax = (longint'(1) <<< (OFF_W - 1)) - 1;
            if (span > smax)
                span = smax;
            if (span < -smax - 1)
                span = -smax - 1;
            res.diff = span[OFF_W-1:0];
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Unused fields of each request get random bits so every input bit toggles.
    function automatic void queue_add(int y, int m, int d, int off);
        date_req_t r;
        r.cmd = CMD_ADD;
        r.year_a = YEAR_W'(y);
        r.month_a = MONTH_W'(m);
        r.dom_a = DOM_W'(d);
        r.offset = OFF_W'(off);
        r.year_b = YEAR_W'($urandom);
        r.month_b = MONTH_W'($urandom);
        r.dom_b = DOM_W'($urandom);
        pending_requests.push_back(r);
    endfunction

    function automatic void queue_diff(int ya, int ma, int da, int yb, int mb, int db);
        date_req_t r;
        r.cmd = CMD_DIFF;
        r.year_a = YEAR_W'(ya);
        r.month_a = MONTH_W'(ma);
        r.dom_a = DOM_W'(da);
        r.offset = OFF_W'($urandom);
        r.year_b = YEAR_W'(yb);
        r.month_b = MONTH_W'(mb);
        r.dom_b = DOM_W'(db);
        pending_requests.push_back(r);
    endfunction

    // Favor the calendar's edges and century years.
    function automatic int pick_year();
        case ($urandom_range(0, 5))
            0: return int'($urandom_range(1, 5));
            1: return int'($urandom_range(9995, 9999));
            2: return 100 * int'($urandom_range(1, 99));
            3: return 400 * int'($urandom_range(1, 24));
            default: return int'($urandom_range(1, 9999));
        endcase
    endfunction

    function automatic void pick_date(output int y, output int m, output int d);
        y = pick_year();
        m = int'($urandom_range(1, 12));
        if ($urandom_range(0, 3) == 0)
            d = month_days(y, m);
        else
            d = int'($urandom_range(1, month_days(y, m)));
    endfunction

    // Break exactly one field of a valid date.
    function automatic void spoil_date(inout int y, inout int m, inout int d);
        case ($urandom_range(0, 5))
            0: y = 0;
            1: y = int'($urandom_range(10000, 16383));
            2: m = 0;
            3: m = int'($urandom_range(13, 15));
            4: d = 0;
            default: d = (month_days(y, m) < 31) ?
                          int'($urandom_range(month_days(y, m) + 1, 31)) : 0;
        endcase
    endfunction

    // Offset for an add from serial s: small, medium, any width, aimed at an edge, or at late February.
    function automatic int pick_offset(int s);
        logic signed [OFF_W-1:0] raw;
        raw = OFF_W'($urandom);
        case ($urandom_range(0, 5))
            0: return int'($urandom_range(0, 800)) - 400;
            1: return int'($urandom_range(0, 100000)) - 50000;
            2: return int'(raw);
            3: return int'($urandom_range(0, 6)) - 3 - s;
            4: return MAX_SERIAL + int'($urandom_range(0, 6)) - 3 - s;
            default: return day_serial(pick_year(), 2, 28) + int'($urandom_range(0, 2)) - s;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driver: present requests in bursts, hold each until start meets !busy
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : drive_requests
        logic fire;
        if (rst_n)
        begin
            fire = start && !busy;
            if (fire)
            begin
                awaited_results.push_back(calc_date_result(active_request));
                requests_sent++;
                if (burst_left > 1)
                begin
                    burst_left--;
                end
                else
                begin
                    // open a new burst after a gap of random length
                    burst_left = int'($urandom_range(1, 16));
                    case ($urandom_range(0, 3))
                        0: gap_left = 0;
                        1, 2: gap_left = int'($urandom_range(1, 8));
                        default: gap_left = int'($urandom_range(20, 180));
                    endcase
                end
            end

            if (start && !fire)
            begin
                // hold: request still waiting for the block
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                start <= 1'b0;
            end
            else if (pending_requests.size() > 0)
            begin
                active_request = pending_requests.pop_front();
                command <= active_request.cmd;
                year_a <= active_request.year_a;
                month_a <= active_request.month_a;
                dom_a <= active_request.dom_a;
                day_offset <= active_request.offset;
                year_b <= active_request.year_b;
                month_b <= active_request.month_b;
                dom_b <= active_request.dom_b;
                start <= 1'b1;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: take every done strobe, match it to the oldest awaited result
    // ------------------------------------------------------------------
    task automatic compare_field(input string what, input logic signed [63:0] want,
                                 input logic signed [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin : watch_results
        date_res_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (awaited_results.size() == 0)
                begin
                    $display("%0t: result with no request pending, status %0d",
                             $time, status);
                    mismatches++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    compare_field("result_year", want.year, result_year);
                    compare_field("result_month", want.month, result_month);
                    compare_field("result_dom", want.dom, result_dom);
                    compare_field("day_difference", want.diff, day_difference);
                    compare_field("status", want.status, status);
                end
            end
            // advance the watchdog unless something moved this cycle
            if ((start && !busy) || done)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
    end

    // Watchdog: drop the run if no request is accepted and no result arrives for too long.
    initial
    begin
        while (idle_cycles < IDLE_LIMIT)
            @(posedge clk);
        $display("%0t: watchdog expired after %0d idle cycles", $time, IDLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin
        int total;
        int kind, y, m, d, y2, m2, d2, side;

        // directed: calendar edges, period boundaries, leap rules, bad dates
        queue_add(1, 1, 1, 0);
        queue_add(1, 1, 1, -1);
        queue_add(9999, 12, 31, 1);
        queue_add(9999, 12, 31, 0);
        queue_add(1, 1, 1, 4194303);
        queue_add(9999, 12, 31, -4194304);
        queue_add(1, 1, 1, MAX_SERIAL);
        queue_add(9999, 12, 31, -MAX_SERIAL);
        queue_add(2000, 2, 28, 1);      // divisible by 400: leap
        queue_add(1900, 2, 28, 1);      // century: common year
        queue_add(2004, 2, 28, 1);
        queue_add(2023, 12, 31, 1);
        queue_add(2000, 2, 29, 365);
        queue_add(0, 6, 15, 10);
        queue_add(16383, 15, 31, 0);
        queue_add(2021, 13, 1, 0);
        queue_add(2021, 4, 31, 0);
        queue_add(2001, 2, 29, 0);
        queue_add(2021, 5, 0, 0);
        queue_diff(9999, 12, 31, 1, 1, 1);
        queue_diff(1, 1, 1, 9999, 12, 31);
        queue_diff(2024, 3, 1, 2024, 3, 1);
        queue_diff(2024, 3, 1, 2023, 0, 1);   // bad date B only
        queue_diff(10000, 1, 1, 2023, 1, 1);  // bad date A only
        queue_diff(1600, 2, 29, 1700, 2, 29);

        // random: mostly valid dates, some broken fields, some raw bits
        for (int i = 0; i < RANDOM_REQUESTS; i++)
        begin
            kind = int'($urandom_range(0, 99));
            pick_date(y, m, d);
            pick_date(y2, m2, d2);
            if (kind < 45)
            begin
                queue_add(y, m, d, pick_offset(day_serial(y, m, d)));
            end
            else if (kind < 80)
            begin
                queue_diff(y, m, d, y2, m2, d2);
            end
            else if (kind < 92)
            begin
                side = int'($urandom_range(0, 2));
                if (side == 2)
                    spoil_date(y2, m2, d2);
                else
                    spoil_date(y, m, d);
                if (side == 0)
                    queue_add(y, m, d, int'($urandom_range(0, 2000)) - 1000);
                else
                    queue_diff(y, m, d, y2, m2, d2);
            end
            else if (kind < 96)
            begin
                queue_add(int'($urandom_range(0, 16383)), int'($urandom_range(0, 15)),
                          int'($urandom_range(0, 31)), int'($urandom));
            end
            else
            begin
                queue_diff(int'($urandom_range(0, 16383)), int'($urandom_range(0, 15)),
                           int'($urandom_range(0, 31)), int'($urandom_range(0, 16383)),
                           int'($urandom_range(0, 15)), int'($urandom_range(0, 31)));
            end
        end
        total = pending_requests.size();

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        while (requests_sent < total)
            @(posedge clk);
        while (awaited_results.size() != 0)
            @(posedge clk);
        // let any stray strobe show up before the verdict
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && awaited_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/gda_pkg.sv
sv/gda_alu.sv
sv/gregorian_date_add_and_difference.sv
tb/tb_gregorian_date_add_and_difference.sv
